>>> rtl/qpht_pkg.sv
// qpht_pkg: types and constants for the quadratic probe hash table.
// No dependencies.
package qpht_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_ERASE  = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_EXISTED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ERASED    = 3'd4,
		ST_FULL      = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_HASH,
		S_FIN1,
		S_FIN2,
		S_FIN3,
		S_READ,
		S_WAIT,
		S_CHECK,
		S_LIMIT,
		S_DONE
	} state_t;

	localparam logic [3:0] REG_KEY_BYTES  = 4'd0;
	localparam logic [3:0] REG_FILL_LIMIT = 4'd1;

	localparam logic [31:0] MARK_UNUSED = 32'd0;
	localparam logic [31:0] MARK_TOMB   = 32'd1;
	localparam logic [31:0] HASH_MIN    = 32'd3;

	// one-at-a-time: absorb one byte
	function automatic logic [31:0] oaat_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {24'd0, b};
		t = t + (t << 10);
		t = t ^ (t >> 6);
		return t;
	endfunction

endpackage

>>> rtl/quadratic_probe_hash_table.sv
// quadratic_probe_hash_table: top level, sequencer and datapath.
// Depends on qpht_pkg and qpht_mem.
//
// Usage
//   Command channel: drive cmd, key, entry_value and pulse start while busy is
//   low; the beat is taken on that edge and busy rises on the next cycle.
//   Result channel: done is high for one cycle with status, stored_value and
//   slot_index. The receiver cannot stall; it must take the beat then.
//   Config: cfg_we/cfg_index/cfg_data, written on any edge with cfg_we high;
//   the user must write them only while idle; the block does not enforce it.
// Sequence
//   A command hashes one key byte per cycle (1..8), finishes the hash in
//   S_FIN1, S_FIN2 and S_FIN3, then probes the table through a single memory
//   port; each probe step is S_READ (address), S_WAIT (read latency), S_CHECK
//   (compare). After the probe come the fill limit test (S_LIMIT) and the done
//   cycle (S_DONE), which also does the write. Clear keeps busy high for a
//   sweep of the marks one slot a cycle, then done.
//   One command at a time; the next beat is taken from the cycle after done.
// Reset
//   arst_n resets control and config registers and clears the occupancy count;
//   then the block runs a clearing pass over every mark with busy high.
//   Keys and values are never cleared; a key is only read behind a live mark.
module quadratic_probe_hash_table #(
	parameter int SLOTS       = 1024,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [63:0] key,
	input  logic [63:0] entry_value,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] stored_value,
	output logic [9:0]  slot_index,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import qpht_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = AW + 1;
	localparam int MAXB_RAW = KEY_WIDTH / 8;
	localparam int MAXB = (MAXB_RAW < 1) ? 1 : ((MAXB_RAW > 8) ? 8 : MAXB_RAW);

	state_t state_q, state_d;

	logic [3:0]             key_bytes_q;
	logic [6:0]             fill_q;
	logic [CW-1:0]          count_q;
	logic [1:0]             cmd_q;
	logic [63:0]            key_q;      // masked key
	logic [63:0]            kmask_q;
	logic [VALUE_WIDTH-1:0] nval_q;
	logic [3:0]             nbytes_q;
	logic [3:0]             bidx_q;
	logic [31:0]            h_q;
	logic [AW-1:0]          pos_q;
	logic [CW-1:0]          step_q;     // probe steps taken
	logic [AW-1:0]          tomb_q;
	logic                   have_tomb_q;
	logic                   hit_unused_q;
	logic [AW-1:0]          clr_q;
	logic [2:0]             st_q;
	logic [63:0]            val_q;
	logic [AW-1:0]          slot_q;
	logic                   wr_q;       // insert writes at slot_q
	logic                   tb_q;       // erase writes tombstone at slot_q
	logic [40:0]            lhs_q, rhs_q;

	// memory port
	logic [AW-1:0]          m_addr;
	logic                   m_we_mark, m_we_kv;
	logic [31:0]            m_wmark;
	logic [31:0]            m_rmark;
	logic [KEY_WIDTH-1:0]   m_rkey;
	logic [VALUE_WIDTH-1:0] m_rval;

	qpht_mem #(.SLOTS(SLOTS), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
		.clk    (clk),
		.addr   (m_addr),
		.we_mark(m_we_mark),
		.we_kv  (m_we_kv),
		.wmark  (m_wmark),
		.wkey   (key_q[KEY_WIDTH-1:0]),
		.wvalue (nval_q),
		.rmark  (m_rmark),
		.rkey   (m_rkey),
		.rvalue (m_rval)
	);

	// effective byte count
	logic [3:0] nb;
	always_comb begin
		nb = key_bytes_q;
		if (nb == 4'd0) nb = 4'd1;
		if (nb > 4'(MAXB)) nb = 4'(MAXB);
	end

	logic [63:0] kmask_d;
	assign kmask_d = ~64'd0 >> (7'd64 - {nb, 3'b000});

	// hash finishing steps
	logic [31:0] f1, f2, f3;
	assign f1 = h_q + (h_q << 3);
	assign f2 = h_q ^ (h_q >> 11);
	assign f3 = h_q + (h_q << 15);

	logic [7:0] cur_byte;
	assign cur_byte = key_q[{bidx_q[2:0], 3'b000} +: 8];

	// compare on the read data
	logic [63:0] rkey_ext;
	assign rkey_ext = 64'(m_rkey);
	logic key_eq;
	assign key_eq = (rkey_ext & kmask_q) == key_q;

	logic [AW-1:0] next_pos;
	assign next_pos = pos_q + AW'(step_q) + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		m_addr    = pos_q;
		m_we_mark = 1'b0;
		m_we_kv   = 1'b0;
		m_wmark   = h_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = (cmd_t'(cmd) == CMD_CLEAR) ? S_CLEAR : S_HASH;
			S_CLEAR: begin
				m_addr    = clr_q;
				m_we_mark = 1'b1;
				m_wmark   = MARK_UNUSED;
				if (clr_q == AW'(SLOTS - 1)) state_d = (cmd_q == CMD_CLEAR) ? S_DONE : S_IDLE;
			end
			S_HASH:  if (bidx_q + 4'd1 == nbytes_q) state_d = S_FIN1;
			S_FIN1:  state_d = S_FIN2;
			S_FIN2:  state_d = S_FIN3;
			S_FIN3:  state_d = S_READ;
			S_READ:  state_d = S_WAIT;
			S_WAIT:  state_d = S_CHECK;
			S_CHECK: begin
				if ((m_rmark == h_q && key_eq) || m_rmark == MARK_UNUSED ||
				    step_q + CW'(1) == CW'(SLOTS)) state_d = S_LIMIT;
				else state_d = S_READ;
			end
			S_LIMIT: state_d = S_DONE;
			S_DONE: begin
				m_addr    = slot_q;
				m_we_mark = wr_q | tb_q;
				m_we_kv   = wr_q;
				m_wmark   = tb_q ? MARK_TOMB : h_q;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q  <= 4'd8;
			fill_q       <= 7'd75;
			count_q      <= '0;
			cmd_q        <= CMD_FIND;
			clr_q        <= '0;
			bidx_q       <= '0;
			step_q       <= '0;
			have_tomb_q  <= 1'b0;
			hit_unused_q <= 1'b0;
			hit_q        <= 1'b0;
			wr_q         <= 1'b0;
			tb_q         <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_KEY_BYTES)  key_bytes_q <= cfg_data[3:0];
			if (cfg_we && cfg_index == REG_FILL_LIMIT) fill_q      <= cfg_data;
			case (state_q)
				S_IDLE: if (start) begin
					cmd_q       <= cmd;
					clr_q       <= '0;
					bidx_q      <= '0;
					step_q      <= '0;
					have_tomb_q <= 1'b0;
					hit_unused_q<= 1'b0;
					hit_q       <= 1'b0;
					wr_q        <= 1'b0;
					tb_q        <= 1'b0;
					if (cmd_t'(cmd) == CMD_CLEAR) count_q <= '0;
				end
				S_CLEAR: clr_q <= clr_q + AW'(1);
				S_HASH:  bidx_q <= bidx_q + 4'd1;
				S_CHECK: begin
					if (m_rmark == h_q) begin
						if (key_eq) hit_q <= 1'b1;
					end else if (m_rmark == MARK_UNUSED) begin
						hit_unused_q <= 1'b1;
					end else if (m_rmark == MARK_TOMB) begin
						have_tomb_q <= 1'b1;
					end
					if (!((m_rmark == h_q && key_eq) || m_rmark == MARK_UNUSED))
						step_q <= step_q + CW'(1);
				end
				S_LIMIT: begin
					if (cmd_q == CMD_ERASE && hit_q) begin
						tb_q <= 1'b1;
						if (count_q != '0) count_q <= count_q - CW'(1);
					end
					if (cmd_q == CMD_INSERT && !hit_q && lhs_q < rhs_q &&
					    (have_tomb_q || hit_unused_q)) begin
						wr_q    <= 1'b1;
						count_q <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers (no reset)
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q    <= key & kmask_d;
				kmask_q  <= kmask_d;
				nbytes_q <= nb;
				nval_q   <= entry_value[VALUE_WIDTH-1:0];
				h_q      <= '0;
				// fill-limit test operands: count*100 vs limit*SLOTS
				rhs_q    <= 41'(fill_q) * 41'(SLOTS);
			end
			S_HASH: h_q <= oaat_step(h_q, cur_byte);
			S_FIN1: h_q <= f1;
			S_FIN2: h_q <= f2;
			S_FIN3: begin
				h_q   <= (f3 <= 32'd2) ? HASH_MIN : f3;
				pos_q <= AW'((f3 <= 32'd2) ? HASH_MIN : f3);
				lhs_q <= 41'(count_q) * 41'd100;
			end
			S_CHECK: begin
				if (m_rmark == MARK_TOMB) tomb_q <= pos_q;
				if (!((m_rmark == h_q && key_eq) || m_rmark == MARK_UNUSED))
					pos_q <= next_pos;
			end
			S_LIMIT: begin
				if (cmd_q == CMD_FIND && hit_q) begin
					st_q <= ST_FOUND;    val_q <= 64'(m_rval); slot_q <= pos_q;
				end else if (cmd_q == CMD_ERASE && hit_q) begin
					st_q <= ST_ERASED;   val_q <= 64'(m_rval); slot_q <= pos_q;
				end else if (cmd_q == CMD_INSERT && hit_q) begin
					st_q <= ST_EXISTED;  val_q <= 64'(m_rval); slot_q <= pos_q;
				end else if (cmd_q == CMD_INSERT &&
				             (lhs_q >= rhs_q || !(have_tomb_q || hit_unused_q))) begin
					st_q <= ST_FULL;     val_q <= '0;          slot_q <= pos_q;
				end else if (cmd_q == CMD_INSERT) begin
					st_q   <= ST_INSERTED;
					val_q  <= 64'(nval_q);
					slot_q <= have_tomb_q ? tomb_q : pos_q;
				end else begin
					st_q <= ST_NOT_FOUND; val_q <= '0;         slot_q <= pos_q;
				end
			end
			S_CLEAR: begin
				st_q  <= ST_CLEARED;
				val_q <= '0;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	logic show_slot;
	assign show_slot = (st_q == ST_FOUND) || (st_q == ST_ERASED) ||
	                   (st_q == ST_EXISTED) || (st_q == ST_INSERTED);

	assign status       = st_q;
	assign stored_value = val_q;
	assign slot_index   = show_slot ? 10'(32'(slot_q)) : 10'd0;
endmodule

>>> rtl/qpht_mem.sv
// qpht_mem: slot storage (marks, keys, values), one port, registered read.
// Depends on nothing.
module qpht_mem #(
	parameter int SLOTS       = 1024,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                     clk,
	input  logic [$clog2(SLOTS)-1:0] addr,
	input  logic                     we_mark,
	input  logic                     we_kv,
	input  logic [31:0]              wmark,
	input  logic [KEY_WIDTH-1:0]     wkey,
	input  logic [VALUE_WIDTH-1:0]   wvalue,
	output logic [31:0]              rmark,
	output logic [KEY_WIDTH-1:0]     rkey,
	output logic [VALUE_WIDTH-1:0]   rvalue
);
	logic [31:0]            mark_mem [SLOTS];
	logic [KEY_WIDTH-1:0]   key_mem  [SLOTS];
	logic [VALUE_WIDTH-1:0] val_mem  [SLOTS];

	always_ff @(posedge clk) begin
		if (we_mark) mark_mem[addr] <= wmark;
		rmark <= mark_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (we_kv) begin
			key_mem[addr] <= wkey;
			val_mem[addr] <= wvalue;
		end
		rkey   <= key_mem[addr];
		rvalue <= val_mem[addr];
	end
endmodule

>>> rtl/qpht_checker.sv
// qpht_checker: port-level assertions for quadratic_probe_hash_table.
// Depends on qpht_pkg; bound to the top level.
module qpht_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] status
);
	import qpht_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("beat taken but not busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");

	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_CLEARED)) else $error("bad status");
endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .status(status)
);
